// ===== hdl/cdau_pkg.sv =====
// Shared types, constants and calendar functions for the calendar date arithmetic unit.
`timescale 1ns / 1ps

package cdau_pkg;

  // Command codes carried with each word.
  typedef enum logic [1:0] {
    CMD_NEXT  = 2'd0,
    CMD_PREV  = 2'd1,
    CMD_CMP   = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_t;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  localparam int unsigned         COUNT_BITS = 23;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Control and status that travel with a word between pipeline stages.
  typedef struct packed {
    cmd_t       cmd;
    logic       a_ok;
    logic       b_ok;
    logic       step_ok;
    logic [4:0] step_day;
    logic [3:0] step_month;
  } ctrl_t;

  // Length of a month under the divisible-by-four leap rule.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of the month, for a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Calendar check on one date.
  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m, input logic leap);
    return (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d >= DAY_FIRST) &&
           (d <= month_len(m, leap));
  endfunction

endpackage

// ===== hdl/calendar_date_arith_unit.sv =====
// Top level of the calendar date arithmetic unit: three-stage pipeline and flow control.
//
//   Channel | Handshake               | Word
//   --------+-------------------------+--------------------------------------------------
//   in      | in_valid / in_stall     | cmd, a_day, a_month, a_year, b_day, b_month, b_year
//   out     | out_valid / out_stall   | a_is_valid, res_valid, res_day, res_month,
//           |                         | res_year, is_less, is_equal, is_greater, day_count
//
// One word is accepted per cycle while in_stall is low; words leave in order of arrival.
// The stages are decode, day-number multiply, and compare/subtract into the output register.
// A stalled output holds its word; bubbles between stages close up, so in_stall only rises
// when all three stages hold words and the output is stalled.
// Reset is synchronous and clears the stage valid bits only.
`timescale 1ns / 1ps

module calendar_date_arith_unit #(
  parameter int YEAR_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      cmd,
  input  logic [4:0]                      a_day,
  input  logic [3:0]                      a_month,
  input  logic [YEAR_BITS-1:0]            a_year,
  input  logic [4:0]                      b_day,
  input  logic [3:0]                      b_month,
  input  logic [YEAR_BITS-1:0]            b_year,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            a_is_valid,
  output logic                            res_valid,
  output logic [4:0]                      res_day,
  output logic [3:0]                      res_month,
  output logic [YEAR_BITS-1:0]            res_year,
  output logic                            is_less,
  output logic                            is_equal,
  output logic                            is_greater,
  output logic [cdau_pkg::COUNT_BITS-1:0] day_count
);
  import cdau_pkg::*;

  localparam int DN_BITS = YEAR_BITS + 10;

  logic                 adv1;
  logic                 adv2;
  logic                 adv3;
  logic                 s1_valid;
  ctrl_t                s1_ctrl;
  logic [YEAR_BITS-1:0] s1_step_year;
  logic [YEAR_BITS-1:0] s1_a_year;
  logic [YEAR_BITS-1:0] s1_b_year;
  logic [YEAR_BITS:0]   s1_a_off;
  logic [YEAR_BITS:0]   s1_b_off;
  logic                 s2_valid;
  ctrl_t                s2_ctrl;
  logic [YEAR_BITS-1:0] s2_step_year;
  logic [DN_BITS-1:0]   s2_a_num;
  logic [DN_BITS-1:0]   s2_b_num;

  // A stage loads when it is empty or its word moves on in the same cycle.
  assign adv3     = ~out_valid | ~out_stall;
  assign adv2     = ~s2_valid | adv3;
  assign adv1     = ~s1_valid | adv2;
  assign in_stall = ~adv1;

  cdau_decode #(.YEAR_BITS(YEAR_BITS)) u_decode (
    .clk          (clk),
    .rst          (rst),
    .advance      (adv1),
    .in_valid     (in_valid),
    .cmd          (cmd_t'(cmd)),
    .a_day        (a_day),
    .a_month      (a_month),
    .a_year       (a_year),
    .b_day        (b_day),
    .b_month      (b_month),
    .b_year       (b_year),
    .s1_valid     (s1_valid),
    .s1_ctrl      (s1_ctrl),
    .s1_step_year (s1_step_year),
    .s1_a_year    (s1_a_year),
    .s1_b_year    (s1_b_year),
    .s1_a_off     (s1_a_off),
    .s1_b_off     (s1_b_off)
  );

  cdau_daynum #(.YEAR_BITS(YEAR_BITS)) u_daynum (
    .clk          (clk),
    .rst          (rst),
    .advance      (adv2),
    .s1_valid     (s1_valid),
    .s1_ctrl      (s1_ctrl),
    .s1_step_year (s1_step_year),
    .s1_a_year    (s1_a_year),
    .s1_b_year    (s1_b_year),
    .s1_a_off     (s1_a_off),
    .s1_b_off     (s1_b_off),
    .s2_valid     (s2_valid),
    .s2_ctrl      (s2_ctrl),
    .s2_step_year (s2_step_year),
    .s2_a_num     (s2_a_num),
    .s2_b_num     (s2_b_num)
  );

  cdau_result #(.YEAR_BITS(YEAR_BITS)) u_result (
    .clk          (clk),
    .rst          (rst),
    .advance      (adv3),
    .s2_valid     (s2_valid),
    .s2_ctrl      (s2_ctrl),
    .s2_step_year (s2_step_year),
    .s2_a_num     (s2_a_num),
    .s2_b_num     (s2_b_num),
    .out_valid    (out_valid),
    .a_is_valid   (a_is_valid),
    .res_valid    (res_valid),
    .res_day      (res_day),
    .res_month    (res_month),
    .res_year     (res_year),
    .is_less      (is_less),
    .is_equal     (is_equal),
    .is_greater   (is_greater),
    .day_count    (day_count)
  );

`ifndef SYNTHESIS
  // Every command needs a valid date A before its result can be valid.
  a_res_needs_a: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_valid |-> a_is_valid)
    else $error("valid result with invalid date A");

  // An invalid result carries a zero date.
  a_zero_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res_valid |-> res_day == 5'd0 && res_month == 4'd0 && res_year == '0)
    else $error("date fields set on invalid result");

  // Compare flags are exclusive and only come with a valid result.
  a_cmp_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_less || is_equal || is_greater) |->
      res_valid && $onehot({is_less, is_equal, is_greater}))
    else $error("compare flags inconsistent");

  // A non-zero count never comes with a date result.
  a_count_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && day_count != '0 |-> res_valid && res_month == 4'd0 && !is_equal)
    else $error("day count mixed with other results");
`endif

endmodule

// ===== hdl/cdau_decode.sv =====
// First pipeline stage: validity checks, next and previous day, day-of-year offsets.
`timescale 1ns / 1ps

module cdau_decode #(
  parameter int YEAR_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  cdau_pkg::cmd_t        cmd,
  input  logic [4:0]            a_day,
  input  logic [3:0]            a_month,
  input  logic [YEAR_BITS-1:0]  a_year,
  input  logic [4:0]            b_day,
  input  logic [3:0]            b_month,
  input  logic [YEAR_BITS-1:0]  b_year,
  output logic                  s1_valid,
  output cdau_pkg::ctrl_t       s1_ctrl,
  output logic [YEAR_BITS-1:0]  s1_step_year,
  output logic [YEAR_BITS-1:0]  s1_a_year,
  output logic [YEAR_BITS-1:0]  s1_b_year,
  output logic [YEAR_BITS:0]    s1_a_off,
  output logic [YEAR_BITS:0]    s1_b_off
);
  import cdau_pkg::*;

  logic                 a_leap;
  logic                 b_leap;
  logic [4:0]           a_len;
  ctrl_t                ctrl_next;
  logic [YEAR_BITS-1:0] step_year_next;
  logic [YEAR_BITS:0]   a_off_next;
  logic [YEAR_BITS:0]   b_off_next;

  // Offset of a date within its day number: leap days before the year plus day of year.
  function automatic logic [YEAR_BITS:0] year_offset(input logic [YEAR_BITS-1:0] y,
                                                     input logic [3:0] m,
                                                     input logic [4:0] d,
                                                     input logic leap);
    logic [YEAR_BITS:0] quarter;
    logic [8:0]         doy;
    quarter = ({1'b0, y} + (YEAR_BITS+1)'(3)) >> 2;
    doy     = days_before(m) + 9'(d) - 9'd1 + (((m > MONTH_FEB) && leap) ? 9'd1 : 9'd0);
    return quarter + (YEAR_BITS+1)'(doy);
  endfunction

  assign a_leap = (a_year[1:0] == 2'b00);
  assign b_leap = (b_year[1:0] == 2'b00);
  assign a_len  = month_len(a_month, a_leap);

  // Validity and the stepped date of A.
  always_comb begin
    ctrl_next.cmd        = cmd;
    ctrl_next.a_ok       = date_ok(a_day, a_month, a_leap);
    ctrl_next.b_ok       = date_ok(b_day, b_month, b_leap);
    ctrl_next.step_ok    = ctrl_next.a_ok;
    ctrl_next.step_day   = a_day;
    ctrl_next.step_month = a_month;
    step_year_next       = a_year;
    case (cmd)
      CMD_NEXT: begin
        if (a_day < a_len) begin
          ctrl_next.step_day = a_day + 5'd1;
        end else if (a_month < MONTH_DEC) begin
          ctrl_next.step_day   = DAY_FIRST;
          ctrl_next.step_month = a_month + 4'd1;
        end else begin
          ctrl_next.step_day   = DAY_FIRST;
          ctrl_next.step_month = MONTH_JAN;
          step_year_next       = a_year + YEAR_BITS'(1);
          if (&a_year) begin
            ctrl_next.step_ok = 1'b0;
          end
        end
      end
      CMD_PREV: begin
        if (a_day > DAY_FIRST) begin
          ctrl_next.step_day = a_day - 5'd1;
        end else if (a_month > MONTH_JAN) begin
          ctrl_next.step_month = a_month - 4'd1;
          ctrl_next.step_day   = month_len(a_month - 4'd1, a_leap);
        end else begin
          ctrl_next.step_month = MONTH_DEC;
          ctrl_next.step_day   = DAY_LAST;
          step_year_next       = a_year - YEAR_BITS'(1);
          if (a_year == '0) begin
            ctrl_next.step_ok = 1'b0;
          end
        end
      end
      default: begin
        ctrl_next.step_ok = ctrl_next.a_ok;
      end
    endcase
  end

  assign a_off_next = year_offset(a_year, a_month, a_day, a_leap);
  assign b_off_next = year_offset(b_year, b_month, b_day, b_leap);

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctrl      <= ctrl_next;
      s1_step_year <= step_year_next;
      s1_a_year    <= a_year;
      s1_b_year    <= b_year;
      s1_a_off     <= a_off_next;
      s1_b_off     <= b_off_next;
    end
  end

endmodule

// ===== hdl/cdau_daynum.sv =====
// Second pipeline stage: serial day numbers of both dates.
`timescale 1ns / 1ps

module cdau_daynum #(
  parameter int YEAR_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   s1_valid,
  input  cdau_pkg::ctrl_t        s1_ctrl,
  input  logic [YEAR_BITS-1:0]   s1_step_year,
  input  logic [YEAR_BITS-1:0]   s1_a_year,
  input  logic [YEAR_BITS-1:0]   s1_b_year,
  input  logic [YEAR_BITS:0]     s1_a_off,
  input  logic [YEAR_BITS:0]     s1_b_off,
  output logic                   s2_valid,
  output cdau_pkg::ctrl_t        s2_ctrl,
  output logic [YEAR_BITS-1:0]   s2_step_year,
  output logic [YEAR_BITS+9:0]   s2_a_num,
  output logic [YEAR_BITS+9:0]   s2_b_num
);
  import cdau_pkg::*;

  localparam int DN_BITS = YEAR_BITS + 10;

  logic [DN_BITS-1:0] a_num_next;
  logic [DN_BITS-1:0] b_num_next;

  // Day number: 365 days per year plus the offset from the first stage.
  assign a_num_next = DN_BITS'(s1_a_year) * DN_BITS'(365) + DN_BITS'(s1_a_off);
  assign b_num_next = DN_BITS'(s1_b_year) * DN_BITS'(365) + DN_BITS'(s1_b_off);

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctrl      <= s1_ctrl;
      s2_step_year <= s1_step_year;
      s2_a_num     <= a_num_next;
      s2_b_num     <= b_num_next;
    end
  end

endmodule

// ===== hdl/cdau_result.sv =====
// Final pipeline stage: compare, day count with saturation, and the output register.
`timescale 1ns / 1ps

module cdau_result #(
  parameter int YEAR_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            s2_valid,
  input  cdau_pkg::ctrl_t                 s2_ctrl,
  input  logic [YEAR_BITS-1:0]            s2_step_year,
  input  logic [YEAR_BITS+9:0]            s2_a_num,
  input  logic [YEAR_BITS+9:0]            s2_b_num,
  output logic                            out_valid,
  output logic                            a_is_valid,
  output logic                            res_valid,
  output logic [4:0]                      res_day,
  output logic [3:0]                      res_month,
  output logic [YEAR_BITS-1:0]            res_year,
  output logic                            is_less,
  output logic                            is_equal,
  output logic                            is_greater,
  output logic [cdau_pkg::COUNT_BITS-1:0] day_count
);
  import cdau_pkg::*;

  localparam int DN_BITS = YEAR_BITS + 10;
  localparam int WIDE    = (DN_BITS > COUNT_BITS) ? DN_BITS : COUNT_BITS;

  logic                  both_ok;
  logic                  is_step;
  logic                  rv_next;
  logic                  date_on;
  logic                  cmp_on;
  logic                  a_lt;
  logic                  a_gt;
  logic [WIDE-1:0]       diff;
  logic [COUNT_BITS-1:0] count_next;

  assign both_ok = s2_ctrl.a_ok & s2_ctrl.b_ok;
  assign is_step = (s2_ctrl.cmd == CMD_NEXT) || (s2_ctrl.cmd == CMD_PREV);
  assign rv_next = is_step ? s2_ctrl.step_ok : both_ok;
  assign date_on = is_step & s2_ctrl.step_ok;
  assign cmp_on  = (s2_ctrl.cmd == CMD_CMP) & both_ok;
  assign a_lt    = s2_a_num < s2_b_num;
  assign a_gt    = s2_a_num > s2_b_num;
  assign diff    = WIDE'(s2_a_num) - WIDE'(s2_b_num);

  // Day count from B up to A, held at the largest code when it does not fit.
  always_comb begin
    count_next = '0;
    if ((s2_ctrl.cmd == CMD_COUNT) && both_ok && a_gt) begin
      if (diff > WIDE'(COUNT_MAX)) begin
        count_next = COUNT_MAX;
      end else begin
        count_next = COUNT_BITS'(diff);
      end
    end
  end

  // Output word valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  // Output word payload; fields not used by the command are zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_is_valid <= s2_ctrl.a_ok;
      res_valid  <= rv_next;
      res_day    <= date_on ? s2_ctrl.step_day : 5'd0;
      res_month  <= date_on ? s2_ctrl.step_month : 4'd0;
      res_year   <= date_on ? s2_step_year : '0;
      is_less    <= cmp_on & a_lt;
      is_equal   <= cmp_on & ~a_lt & ~a_gt;
      is_greater <= cmp_on & a_gt;
      day_count  <= count_next;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the calendar date arithmetic unit, with directed and random words.
`timescale 1ns / 1ps

module tb_top;
  import cdau_pkg::*;

  localparam int YEAR_W      = 14;
  localparam int YEAR_TOP    = (1 << YEAR_W) - 1;
  localparam int RAND_BLOCKS = 14;
  localparam int BLOCK_WORDS = 100;
  localparam int LONG_HOLD   = 200;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  // One input word: command and the two dates.
  typedef struct packed {
    cmd_t              op;
    logic [4:0]        a_d;
    logic [3:0]        a_m;
    logic [YEAR_W-1:0] a_y;
    logic [4:0]        b_d;
    logic [3:0]        b_m;
    logic [YEAR_W-1:0] b_y;
  } date_word_t;

  // One output word as the unit reports it.
  typedef struct packed {
    logic                  a_ok;
    logic                  res_ok;
    logic [4:0]            day;
    logic [3:0]            month;
    logic [YEAR_W-1:0]     year;
    logic                  lt;
    logic                  eq;
    logic                  gt;
    logic [COUNT_BITS-1:0] count;
  } date_res_t;

  // A word to send, with its result typed in when the row is a fixed one.
  typedef struct packed {
    date_word_t w;
    logic       fixed;
    date_res_t  res;
  } date_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] cmd = '0;
  logic [4:0] a_day = '0;
  logic [3:0] a_month = '0;
  logic [YEAR_W-1:0] a_year = '0;
  logic [4:0] b_day = '0;
  logic [3:0] b_month = '0;
  logic [YEAR_W-1:0] b_year = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic a_is_valid;
  logic res_valid;
  logic [4:0] res_day;
  logic [3:0] res_month;
  logic [YEAR_W-1:0] res_year;
  logic is_less;
  logic is_equal;
  logic is_greater;
  logic [COUNT_BITS-1:0] day_count;

  date_row_t dir_rows[$];
  date_row_t offered_q[$];
  date_res_t due_q[$];

  int  errors = 0;
  int  stuck_cycles = 0;
  int  n_checked = 0;
  int  n_by_cmd[4] = '{0, 0, 0, 0};
  int  n_bad_a = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;
  bit  hold_pending = 1'b0;

  date_row_t acc_row;
  date_res_t got_res;
  date_res_t want_res;

  calendar_date_arith_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .a_day(a_day), .a_month(a_month), .a_year(a_year),
    .b_day(b_day), .b_month(b_month), .b_year(b_year),
    .out_valid(out_valid), .out_stall(out_stall),
    .a_is_valid(a_is_valid), .res_valid(res_valid),
    .res_day(res_day), .res_month(res_month), .res_year(res_year),
    .is_less(is_less), .is_equal(is_equal), .is_greater(is_greater),
    .day_count(day_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Length of a month; every fourth year is a leap year, year 0 included.
  function automatic int month_days(int m, int y);
    if (m == MONTH_FEB) return (y % 4 == 0) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit valid_date(int d, int m, int y);
    return (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Days since 1 January of year 0, for a valid date.
  function automatic longint serial_day(int d, int m, int y);
    longint n;
    n = longint'(y) * 365 + (y + 3) / 4 + d - 1;
    for (int k = 1; k < m; k++) n += month_days(k, y);
    return n;
  endfunction

  // Expected output word for one input word.
  function automatic date_res_t predict_date(date_word_t w);
    date_res_t r;
    bit a_ok, b_ok, ok;
    int d, m, y;
    longint na, nb, diff;
    r = '0;
    a_ok = valid_date(w.a_d, w.a_m, w.a_y);
    b_ok = valid_date(w.b_d, w.b_m, w.b_y);
    ok = 1'b0;
    d = w.a_d;
    m = w.a_m;
    y = w.a_y;
    case (w.op)
      CMD_NEXT: begin
        if (a_ok) begin
          ok = 1'b1;
          d = d + 1;
          if (d > month_days(m, y)) begin
            d = 1;
            m = m + 1;
            if (m > 12) begin
              m = 1;
              if (y == YEAR_TOP) ok = 1'b0;
              else y = y + 1;
            end
          end
        end
      end
      CMD_PREV: begin
        if (a_ok) begin
          ok = 1'b1;
          if (d > 1) begin
            d = d - 1;
          end else if (m > 1) begin
            m = m - 1;
            d = month_days(m, y);
          end else if (y == 0) begin
            ok = 1'b0;
          end else begin
            y = y - 1;
            m = 12;
            d = 31;
          end
        end
      end
      default: begin
        if (a_ok && b_ok) begin
          ok = 1'b1;
          na = serial_day(w.a_d, w.a_m, w.a_y);
          nb = serial_day(w.b_d, w.b_m, w.b_y);
          if (w.op == CMD_CMP) begin
            r.lt = (na < nb);
            r.eq = (na == nb);
            r.gt = (na > nb);
          end else if (na > nb) begin
            diff = na - nb;
            r.count = (diff > longint'(COUNT_MAX)) ? COUNT_MAX : diff[COUNT_BITS-1:0];
          end
        end
      end
    endcase
    r.a_ok = a_ok;
    r.res_ok = ok;
    if (ok && (w.op == CMD_NEXT || w.op == CMD_PREV)) begin
      r.day = d[4:0];
      r.month = m[3:0];
      r.year = y[YEAR_W-1:0];
    end
    return r;
  endfunction

  function automatic date_res_t mk_res(bit a_ok, bit res_ok, int d, int m, int y,
                                       bit lt, bit eq, bit gt, int cnt);
    date_res_t r;
    r.a_ok = a_ok;
    r.res_ok = res_ok;
    r.day = d[4:0];
    r.month = m[3:0];
    r.year = y[YEAR_W-1:0];
    r.lt = lt;
    r.eq = eq;
    r.gt = gt;
    r.count = cnt[COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic void add_row(cmd_t op, int ad, int am, int ay, int bd, int bm, int by,
                                  bit fixed, date_res_t r);
    date_row_t row;
    row.w = '{op, ad[4:0], am[3:0], ay[YEAR_W-1:0], bd[4:0], bm[3:0], by[YEAR_W-1:0]};
    row.fixed = fixed;
    row.res = r;
    dir_rows.push_back(row);
  endfunction

  // One date: mostly well-formed with month edges, some near misses, some raw noise.
  function automatic void pick_date(output logic [4:0] d, output logic [3:0] m,
                                    output logic [YEAR_W-1:0] y);
    int sel, len;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      y = YEAR_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                       : YEAR_TOP - $urandom_range(0, 3));
    else
      y = YEAR_W'($urandom);
    m = 4'($urandom_range(1, 12));
    len = month_days(m, y);
    if (sel < 12) begin
      d = 5'($urandom);
      m = 4'($urandom);
    end else if (sel < 20) begin
      d = 5'((len < 31) ? len + 1 : 0);
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    d = 5'd1;
        2, 3:    d = 5'(len);
        4:       d = 5'(len - 1);
        default: d = 5'($urandom_range(1, len));
      endcase
    end
  endfunction

  function automatic date_row_t random_row();
    date_row_t row;
    row = '0;
    row.w.op = cmd_t'($urandom_range(0, 3));
    pick_date(row.w.a_d, row.w.a_m, row.w.a_y);
    case ($urandom_range(0, 5))
      0: begin
        row.w.b_d = row.w.a_d;
        row.w.b_m = row.w.a_m;
        row.w.b_y = row.w.a_y;
      end
      1: begin
        row.w.b_d = 5'($urandom_range(1, 28));
        row.w.b_m = row.w.a_m;
        row.w.b_y = row.w.a_y;
      end
      default: pick_date(row.w.b_d, row.w.b_m, row.w.b_y);
    endcase
    return row;
  endfunction

  // Present one word after a random gap and hold it until the unit takes it.
  task automatic send_word(date_row_t row);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd     <= row.w.op;
    a_day   <= row.w.a_d;
    a_month <= row.w.a_m;
    a_year  <= row.w.a_y;
    b_day   <= row.w.b_d;
    b_month <= row.w.b_m;
    b_year  <= row.w.b_y;
    in_valid <= 1'b1;
    offered_q.push_back(row);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: a random hold-off before each word, with one long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      n = recv_quiet ? 0 : $urandom_range(0, 14);
      if (hold_pending) begin
        n = LONG_HOLD;
        hold_pending = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Scoreboard: check each word that leaves, then record the expectation of each word taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res = '{a_is_valid, res_valid, res_day, res_month, res_year,
                  is_less, is_equal, is_greater, day_count};
      n_checked++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t ns: result word with none expected, actual %h", $time, got_res);
      end else begin
        want_res = due_q.pop_front();
        check_field("a_is_valid", want_res.a_ok, got_res.a_ok);
        check_field("res_valid", want_res.res_ok, got_res.res_ok);
        check_field("res_day", want_res.day, got_res.day);
        check_field("res_month", want_res.month, got_res.month);
        check_field("res_year", want_res.year, got_res.year);
        check_field("is_less", want_res.lt, got_res.lt);
        check_field("is_equal", want_res.eq, got_res.eq);
        check_field("is_greater", want_res.gt, got_res.gt);
        check_field("day_count", want_res.count, got_res.count);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      acc_row = offered_q.pop_front();
      due_q.push_back(acc_row.fixed ? acc_row.res : predict_date(acc_row.w));
      n_by_cmd[acc_row.w.op]++;
      if (!valid_date(acc_row.w.a_d, acc_row.w.a_m, acc_row.w.a_y)) n_bad_a++;
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : main
    date_res_t none;
    date_res_t bad_a;
    date_res_t no_res;
    none   = '0;
    bad_a  = '0;
    no_res = mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0);

    // Directed rows: year wrap at both ends, leap handling, invalid dates, each command.
    add_row(CMD_NEXT, 31, 12, YEAR_TOP, 1, 1, 0, 1, no_res);
    add_row(CMD_PREV, 1, 1, 0, 1, 1, 0, 1, no_res);
    add_row(CMD_NEXT, 28, 2, 2001, 1, 1, 0, 1, mk_res(1, 1, 1, 3, 2001, 0, 0, 0, 0));
    add_row(CMD_NEXT, 28, 2, 2000, 1, 1, 0, 1, mk_res(1, 1, 29, 2, 2000, 0, 0, 0, 0));
    add_row(CMD_NEXT, 29, 2, 1900, 1, 1, 0, 1, mk_res(1, 1, 1, 3, 1900, 0, 0, 0, 0));
    add_row(CMD_PREV, 1, 3, 2000, 1, 1, 0, 1, mk_res(1, 1, 29, 2, 2000, 0, 0, 0, 0));
    add_row(CMD_PREV, 1, 3, 2001, 1, 1, 0, 1, mk_res(1, 1, 28, 2, 2001, 0, 0, 0, 0));
    add_row(CMD_NEXT, 29, 2, 2001, 1, 1, 0, 1, bad_a);
    add_row(CMD_NEXT, 30, 2, 2000, 1, 1, 0, 1, bad_a);
    add_row(CMD_PREV, 31, 4, 2000, 1, 1, 0, 1, bad_a);
    add_row(CMD_NEXT, 0, 5, 2000, 1, 1, 0, 1, bad_a);
    add_row(CMD_PREV, 15, 0, 2000, 1, 1, 0, 1, bad_a);
    add_row(CMD_NEXT, 15, 13, 2000, 1, 1, 0, 1, bad_a);
    add_row(CMD_NEXT, 31, 15, YEAR_TOP, 31, 15, YEAR_TOP, 1, bad_a);
    add_row(CMD_NEXT, 31, 1, 0, 1, 1, 0, 1, mk_res(1, 1, 1, 2, 0, 0, 0, 0, 0));
    add_row(CMD_PREV, 1, 1, YEAR_TOP, 1, 1, 0, 1,
            mk_res(1, 1, 31, 12, YEAR_TOP - 1, 0, 0, 0, 0));
    add_row(CMD_NEXT, 31, 12, 1999, 1, 1, 0, 1, mk_res(1, 1, 1, 1, 2000, 0, 0, 0, 0));
    add_row(CMD_CMP, 15, 6, 2000, 15, 6, 2000, 1, mk_res(1, 1, 0, 0, 0, 0, 1, 0, 0));
    add_row(CMD_CMP, 14, 6, 2000, 15, 6, 2000, 1, mk_res(1, 1, 0, 0, 0, 1, 0, 0, 0));
    add_row(CMD_CMP, 1, 1, 2001, 31, 12, 2000, 1, mk_res(1, 1, 0, 0, 0, 0, 0, 1, 0));
    add_row(CMD_CMP, 1, 1, 2001, 31, 6, 2000, 1, no_res);
    add_row(CMD_COUNT, 1, 1, 0, 31, 12, YEAR_TOP, 1, mk_res(1, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(CMD_COUNT, 31, 12, YEAR_TOP, 1, 1, 0, 1,
            mk_res(1, 1, 0, 0, 0, 0, 0, 0, 5984255));
    add_row(CMD_COUNT, 1, 3, 2000, 28, 2, 2000, 1, mk_res(1, 1, 0, 0, 0, 0, 0, 0, 2));
    add_row(CMD_COUNT, 0, 0, 0, 28, 2, 2000, 0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // Random blocks, cycling through four patterns of gaps on the two sides.
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      send_quiet = (blk % 4 == 1) || (blk % 4 == 2);
      recv_quiet = (blk % 4 == 1) || (blk % 4 == 3);
      if (blk == 2) hold_pending = 1'b1;
      for (int k = 0; k < BLOCK_WORDS; k++) send_word(random_row());
    end
    in_valid <= 1'b0;
    recv_quiet = 1'b0;

    while (due_q.size() != 0 || offered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: %0d next-day, %0d previous-day, %0d compare, %0d count.",
             n_checked, n_by_cmd[CMD_NEXT], n_by_cmd[CMD_PREV], n_by_cmd[CMD_CMP],
             n_by_cmd[CMD_COUNT]);
    $display("Date A was invalid in %0d words; %0d mismatches seen.", n_bad_a, errors);
    if (errors == 0 && due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== calendar_date_arith_unit.f =====
hdl/cdau_pkg.sv
hdl/cdau_decode.sv
hdl/cdau_daynum.sv
hdl/cdau_result.sv
hdl/calendar_date_arith_unit.sv
verif/tb_top.sv
